>>> sv/mkde_pkg.sv
`default_nettype none
package mkde_pkg;

  localparam int ROWS       = 4;
  localparam int COLS       = 4;
  localparam int ROW_W      = 4;
  localparam int COL_W      = 2;
  localparam int CODE_W     = 4;
  localparam int CNT_W      = 3;
  localparam int VAL_W      = 14;
  localparam int MAX_DIGITS = 4;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes, taken from the top bit of the byte address
  localparam logic REG_DIGITS_PER_ENTRY = 1'b0;

  localparam logic [CNT_W-1:0]  DIGITS_RESET   = 3'd2;
  localparam logic [CODE_W-1:0] FIRST_FUNC_KEY = 4'd10;

  // key map, indexed [row][column]
  localparam logic [CODE_W-1:0] KEY_MAP [ROWS][COLS] = '{
    '{4'd1, 4'd2,  4'd3,  4'd10},
    '{4'd4, 4'd5,  4'd6,  4'd11},
    '{4'd7, 4'd8,  4'd9,  4'd12},
    '{4'd0, 4'd15, 4'd14, 4'd13}
  };

  typedef struct packed {
    logic              seen;
    logic [CODE_W-1:0] code;
  } key_t;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic              taken;
    logic              done;
    logic [VAL_W-1:0]  value;
    logic [COLS-1:0]   next_drive;
  } entry_t;

endpackage
`default_nettype wire

>>> sv/mkde_if.sv
`default_nettype none
interface mkde_in_if;
  import mkde_pkg::*;

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_levels;

  modport source (output valid, output row_levels, input ready);
  modport sink (input valid, input row_levels, output ready);
endinterface

interface mkde_out_if;
  import mkde_pkg::*;

  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  scanned_column;
  logic              key_seen;
  logic [CODE_W-1:0] key_code;
  logic              digit_taken;
  logic              entry_done;
  logic [VAL_W-1:0]  entry_value;
  logic [COLS-1:0]   next_column_drive;

  modport source (
    output valid, output scanned_column, output key_seen, output key_code,
    output digit_taken, output entry_done, output entry_value,
    output next_column_drive, input ready
  );
  modport sink (
    input valid, input scanned_column, input key_seen, input key_code,
    input digit_taken, input entry_done, input entry_value,
    input next_column_drive, output ready
  );
endinterface
`default_nettype wire

>>> sv/mkde_decode.sv
`default_nettype none
module mkde_decode (
  input  wire logic [mkde_pkg::ROW_W-1:0] row_levels,
  input  wire logic [mkde_pkg::COL_W-1:0] column,
  output mkde_pkg::key_t                  key
);
  import mkde_pkg::*;

  // lowest-numbered low row wins
  always_comb begin
    key = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (!row_levels[r]) begin
        key.seen = 1'b1;
        key.code = KEY_MAP[r][column];
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/mkde_entry.sv
`default_nettype none
module mkde_entry (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       advance,
  input  wire logic [mkde_pkg::CNT_W-1:0] digits_per_entry,
  input  wire mkde_pkg::key_t             key,
  output logic [mkde_pkg::COL_W-1:0]      column,
  output mkde_pkg::entry_t                res
);
  import mkde_pkg::*;

  logic [COL_W-1:0]  column_r;
  logic [CNT_W-1:0]  count_r;
  logic [VAL_W-1:0]  partial_r;
  logic [COL_W-1:0]  column_nxt;
  logic [CNT_W-1:0]  count_nxt;
  logic [VAL_W-1:0]  partial_nxt;
  logic [CNT_W-1:0]  eff_digits;
  logic [CNT_W:0]    count_inc;
  logic [VAL_W+3:0]  acc_full;
  logic [VAL_W-1:0]  acc;
  logic              taken;
  logic              done;

  // clamp the digit count into 1..MAX_DIGITS
  always_comb begin
    eff_digits = digits_per_entry;
    if (digits_per_entry == '0) begin
      eff_digits = CNT_W'(1);
    end else if (digits_per_entry > CNT_W'(MAX_DIGITS)) begin
      eff_digits = CNT_W'(MAX_DIGITS);
    end
  end

  always_comb begin
    taken     = key.seen && (key.code < FIRST_FUNC_KEY);
    count_inc = {1'b0, count_r} + (CNT_W+1)'(1);
    done      = taken && (count_inc >= {1'b0, eff_digits});
    // times ten as two shifts
    acc_full  = ({4'b0, partial_r} << 3) + ({4'b0, partial_r} << 1)
                + (VAL_W+4)'(key.code);
    acc       = acc_full[VAL_W-1:0];

    column_nxt  = column_r + COL_W'(1);
    count_nxt   = count_r;
    partial_nxt = partial_r;
    if (done) begin
      count_nxt   = '0;
      partial_nxt = '0;
    end else if (taken) begin
      count_nxt   = count_inc[CNT_W-1:0];
      partial_nxt = acc;
    end

    res.column     = column_r;
    res.taken      = taken;
    res.done       = done;
    res.value      = done ? acc : '0;
    res.next_drive = ~(COLS'(1) << column_nxt);
  end

  assign column = column_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r  <= '0;
      count_r   <= '0;
      partial_r <= '0;
    end else if (advance) begin
      column_r  <= column_nxt;
      count_r   <= count_nxt;
      partial_r <= partial_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/matrix_keypad_decimal_entry_core.sv
`default_nettype none
// 4x4 keypad scanner with decimal entry. Each accepted input word is one scan
// tick: the row levels sampled while the current column was driven low. The
// lowest low row picks the key; digit keys 0-9 are shifted into a decimal
// value, and once digits_per_entry digits (clamped to 1..4) are in, the word
// carries entry_done with the value and a new entry starts. Function keys are
// reported but leave the entry alone; there is no debounce. next_column_drive
// gives the active-low pattern for the following tick. One word per cycle:
// a tick is decoded and the scan state updated in the cycle it is accepted,
// and the result sits in one output register, so a new word is taken whenever
// that register is empty or being drained. The register
// digits_per_entry sits at byte address 0 (reset value 2).
module matrix_keypad_decimal_entry_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  mkde_in_if.sink                              in_word,
  mkde_out_if.source                           out_word,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mkde_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [mkde_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [mkde_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import mkde_pkg::*;

  logic [CNT_W-1:0] digits_r;
  logic             reg_sel;
  logic             accept;
  logic             out_valid_r;
  key_t             key;
  key_t             key_r;
  entry_t           res;
  entry_t           res_r;
  logic [COL_W-1:0] column;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_DIGITS_PER_ENTRY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r <= DIGITS_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      digits_r <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = CFG_DATA_W'(digits_r);
    end
  end

  // scan datapath
  assign in_word.ready = !out_valid_r || out_word.ready;
  assign accept        = in_word.valid && in_word.ready;

  mkde_decode u_decode (
    .row_levels (in_word.row_levels),
    .column     (column),
    .key        (key)
  );

  mkde_entry u_entry (
    .clk              (clk),
    .rst_n            (rst_n),
    .advance          (accept),
    .digits_per_entry (digits_r),
    .key              (key),
    .column           (column),
    .res              (res)
  );

  // output register: load on accept, drop valid once drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= key;
      res_r <= res;
    end
  end

  assign out_word.valid             = out_valid_r;
  assign out_word.scanned_column    = res_r.column;
  assign out_word.key_seen          = key_r.seen;
  assign out_word.key_code          = key_r.code;
  assign out_word.digit_taken       = res_r.taken;
  assign out_word.entry_done        = res_r.done;
  assign out_word.entry_value       = res_r.value;
  assign out_word.next_column_drive = res_r.next_drive;

endmodule
`default_nettype wire

>>> verif/matrix_keypad_decimal_entry_core_test.sv
module matrix_keypad_decimal_entry_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mkde_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 11;
  localparam int LONG_HOLD = 80;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [CFG_ADDR_W-1:0] DIGITS_ADDR = {REG_DIGITS_PER_ENTRY, 2'b00};

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic              seen;
    logic [CODE_W-1:0] code;
    logic              taken;
    logic              done;
    logic [VAL_W-1:0]  value;
    logic [COLS-1:0]   next_drive;
  } scan_word_t;

  // key codes indexed [row][column]
  localparam logic [CODE_W-1:0] PAD_CODES [ROWS][COLS] = '{
    '{4'd1, 4'd2,  4'd3,  4'd10},
    '{4'd4, 4'd5,  4'd6,  4'd11},
    '{4'd7, 4'd8,  4'd9,  4'd12},
    '{4'd0, 4'd15, 4'd14, 4'd13}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  mkde_in_if  in_if();
  mkde_out_if out_if();

  matrix_keypad_decimal_entry_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_if),
    .out_word (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // scan state mirrored by the predictor
  logic [COL_W-1:0] scan_column;
  logic [CNT_W-1:0] digits_held;
  logic [VAL_W-1:0] entry_partial;
  logic [CNT_W-1:0] digits_cfg;

  scan_word_t pending_scans[$];

  int  errors;
  int  cycle_count;
  int  ticks_checked;
  int  entries_seen;
  int  hold_left;
  int  stall_left;
  bit  hold_request;
  bit  idle_on;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_scans.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int clamp_digits(input logic [CNT_W-1:0] n);
    if (n < 1) return 1;
    if (n > MAX_DIGITS) return MAX_DIGITS;
    return n;
  endfunction

  // one scan tick: decode the key, advance the entry, rotate the column
  function automatic scan_word_t scan_tick(input logic [ROW_W-1:0] rows);
    scan_word_t w;
    int         cnt;
    w = '0;
    w.column = scan_column;
    for (int r = 0; r < ROWS; r++) begin
      if (!w.seen && !rows[r]) begin
        w.seen = 1'b1;
        w.code = PAD_CODES[r][scan_column];
      end
    end
    if (w.seen && w.code < FIRST_FUNC_KEY) begin
      w.taken = 1'b1;
      entry_partial = VAL_W'(int'(entry_partial) * 10 + int'(w.code));
      cnt = int'(digits_held) + 1;
      if (cnt >= clamp_digits(digits_cfg)) begin
        w.done = 1'b1;
        w.value = entry_partial;
        entry_partial = '0;
        cnt = 0;
      end
      digits_held = CNT_W'(cnt);
    end
    scan_column = scan_column + 1'b1;
    w.next_drive = ~(COLS'(1) << scan_column);
    return w;
  endfunction

  function automatic void check_field(input string field, input logic [15:0] exp_v,
                                      input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    scan_word_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_scans.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual column %0d code %0d",
                 $time, out_if.scanned_column, out_if.key_code);
      end else begin
        w = pending_scans.pop_front();
        ticks_checked++;
        check_field("scanned_column", w.column, out_if.scanned_column);
        check_field("key_seen", w.seen, out_if.key_seen);
        check_field("key_code", w.code, out_if.key_code);
        check_field("digit_taken", w.taken, out_if.digit_taken);
        check_field("entry_done", w.done, out_if.entry_done);
        check_field("entry_value", w.value, out_if.entry_value);
        check_field("next_column_drive", w.next_drive, out_if.next_column_drive);
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_rows(input logic [ROW_W-1:0] rows);
    scan_word_t w;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      in_if.row_levels <= ROW_W'($urandom);
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.row_levels <= rows;
    do @(posedge clk); while (!in_if.ready);
    w = scan_tick(rows);
    if (w.done) entries_seen++;
    pending_scans.push_back(w);
    @(negedge clk);
  endtask

  task automatic drain_scans();
    in_if.valid <= 1'b0;
    while (pending_scans.size() != 0) @(negedge clk);
    // leave a little margin after the queue empties
    repeat (3) @(negedge clk);
  endtask

  task automatic write_digits(input logic [CNT_W-1:0] n, input bit junk_bits);
    logic [CFG_DATA_W-1:0] data;
    data = junk_bits ? CFG_DATA_W'($urandom) : '0;
    data[CNT_W-1:0] = n;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= DIGITS_ADDR;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    digits_cfg = n;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DATA_W'(n)) begin
      errors++;
      $display("%0t: digits_per_entry readback, expected %0d, actual %0d", $time, n, prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_scans(input int count);
    logic [ROW_W-1:0] rows;
    int               pick;
    int               r;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // a pressed key: row r is the lowest low row, higher rows random
        r = $urandom_range(0, ROWS - 1);
        rows = ROW_W'($urandom);
        for (int j = 0; j <= r; j++) rows[j] = (j != r);
      end else if (pick < 85) begin
        rows = '1;
      end else begin
        rows = ROW_W'($urandom);
      end
      send_rows(rows);
    end
  endtask

  // every key once at the reset count of two digits
  task automatic test_key_map();
    logic [ROW_W-1:0] rows;
    int               r;
    for (int i = 0; i < ROWS * COLS; i++) begin
      r = i / COLS;
      rows = ROW_W'($urandom);
      for (int j = 0; j <= r; j++) rows[j] = (j != r);
      send_rows(rows);
    end
  endtask

  // no key, all rows low, and single low rows 3, 2 and 0
  task automatic test_row_patterns();
    send_rows(4'hF);
    send_rows(4'h0);
    send_rows(4'h7);
    send_rows(4'hB);
    send_rows(4'hE);
  endtask

  // walk the digit count through its range, extremes and out-of-range values
  task automatic test_digit_counts();
    logic [CNT_W-1:0] counts[8];
    counts = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd3, 3'd5, 3'd2, 3'd4};
    for (int k = 0; k < 8; k++) begin
      drain_scans();
      write_digits(counts[k], k[0]);
      random_scans(160);
    end
  endtask

  // hold the receiver while words keep coming so the input stalls
  task automatic test_backpressure();
    hold_request = 1'b1;
    random_scans(40);
  endtask

  task automatic test_sender_pause();
    drain_scans();
    random_scans(10);
  endtask

  task automatic test_quiet_tail();
    idle_on = 1'b0;
    random_scans(220);
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.row_levels = '1;
    out_if.ready = 1'b0;
    scan_column = '0;
    digits_held = '0;
    entry_partial = '0;
    digits_cfg = DIGITS_RESET;
    idle_on = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_key_map();
    test_row_patterns();
    test_digit_counts();
    test_backpressure();
    test_sender_pause();
    test_quiet_tail();

    drain_scans();
    repeat (5) @(posedge clk);
    $display("checked %0d scan ticks, %0d completed entries, digit counts 0 to 7",
             ticks_checked, entries_seen);
    $display("covered all 16 keys, stalls on both sides and a long output hold-off");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
